// ===== hw/rtl/sfe_pkg.sv =====
// sfe_pkg: shared types, constants and codes for the secular function evaluator
// used by every module of the block but sfe_div; no dependencies

package sfe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int ACC_W         = 64;
   // divider operand widths: largest dividend is b*b or q*q (< 2^63), divisor is |a - lambda|
   localparam int DVD_W         = 63;
   localparam int DVS_W         = 32;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] diag_entry;
      logic [DATA_W-1:0] spike_entry;
      logic              is_last;
   } req_data_type;

   typedef struct packed {
      logic [DATA_W-1:0] func_value;
      logic [DATA_W-1:0] first_deriv;
      logic [DATA_W-1:0] second_deriv;
      logic              pole_hit;
      logic              saturated;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_BB,
      ST_DIV_T1,
      ST_WAIT_T1,
      ST_DIV_Q,
      ST_WAIT_Q,
      ST_MUL_QQ,
      ST_DIV_T3,
      ST_WAIT_T3,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DIV_T1,
      DIV_Q,
      DIV_T3
   } div_op_type;

   typedef struct packed {
      logic       load_item;
      logic       mul_bb;
      logic       mul_qq;
      logic       div_start;
      div_op_type div_op;
      logic       accum;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic pole;
      logic is_last;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// ===== hw/rtl/sfe_div.sv =====
// sfe_div: unsigned restoring divider, one quotient bit per cycle
// depends on nothing but its parameters

module sfe_div #(
   parameter int DVD_W = 63,
   parameter int DVS_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits back in DVS_W bits
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/sfe_datapath.sv =====
// sfe_datapath: operand registers, shared multiplier, divider, accumulators and result register
// depends on sfe_pkg and sfe_div

module sfe_datapath import sfe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_data_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_valid,
   output rsp_data_type          rsp_data,
   input  logic                  rsp_stall
);

   localparam logic [DVD_W-1:0] Q_POS_LIM = DVD_W'((64'd1 << (DATA_W - 1)) - 64'd1);
   localparam logic [DVD_W-1:0] Q_NEG_LIM = DVD_W'(64'd1 << (DATA_W - 1));
   localparam logic [ACC_W+1:0] ONE_EXT   = (ACC_W+2)'(1) << FRAC_BITS;

   // saturating 64-bit add, returns {overflow, value}
   function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] x,
                                               input logic [ACC_W-1:0] y);
      logic [ACC_W:0] s;
      s = {x[ACC_W-1], x} + {y[ACC_W-1], y};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
      end
      return {1'b0, s[ACC_W-1:0]};
   endfunction

   // clamp a wide sum to 32 bits, returns {clamped, value}
   function automatic logic [DATA_W:0] sat32(input logic [ACC_W+1:0] x);
      if (x[ACC_W+1:DATA_W-1] == '0 || x[ACC_W+1:DATA_W-1] == '1) begin
         return {1'b0, x[DATA_W-1:0]};
      end
      return {1'b1, x[ACC_W+1], {(DATA_W-1){~x[ACC_W+1]}}};
   endfunction

   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [DATA_W-1:0] corner_ff, corner_in;

   logic [DVS_W-1:0]  dmag_ff, dmag_in;
   logic              dneg_ff, dneg_in;
   logic              dzero_ff, dzero_in;
   logic [DATA_W-1:0] bmag_ff, bmag_in;
   logic              bneg_ff, bneg_in;
   logic              last_ff, last_in;

   logic [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0]   mul_a;
   logic [DATA_W-1:0]   qmag_ff, qmag_in;
   logic [ACC_W-1:0]    t1_ff, t1_in;
   logic [ACC_W-1:0]    t3_ff, t3_in;
   div_op_type          div_op_ff, div_op_in;

   logic [ACC_W-1:0] sum_func_ff, sum_func_in;
   logic [ACC_W-1:0] sum_first_ff, sum_first_in;
   logic [ACC_W-1:0] sum_second_ff, sum_second_in;
   logic             pole_flag_ff, pole_flag_in;
   logic             clamp_flag_ff, clamp_flag_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic [DATA_W:0]  d_full;
   logic [DATA_W:0]  d_neg;
   logic [DVD_W-1:0] dvd;
   logic             div_done;
   logic [DVD_W-1:0] quo;
   logic [ACC_W-1:0] quo_term;
   logic [DVD_W-1:0] q_lim;
   logic [ACC_W-1:0] t2;
   logic [ACC_W:0]   add_func, add_first, add_second;
   logic [DATA_W:0]  lam_c;
   logic [DATA_W:0]  res_func, res_first, res_second;
   logic             out_free;

   // item difference a - lambda, exact in 33 bits
   assign d_full = {req_data.diag_entry[DATA_W-1], req_data.diag_entry}
                 - {shift_ff[DATA_W-1], shift_ff};
   assign d_neg  = ~d_full + (DATA_W+1)'(1);

   assign mul_a   = cmd.mul_qq ? qmag_ff : bmag_ff;
   assign prod_in = (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_a);

   always_comb begin
      unique case (cmd.div_op)
         DIV_Q:   dvd = DVD_W'(bmag_ff) << FRAC_BITS;
         default: dvd = prod_ff[DVD_W-1:0];
      endcase
   end

   sfe_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_sfe_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dmag_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // quotient takes the sign of the difference (truncation toward zero)
   assign quo_term = dneg_ff ? (~{1'b0, quo} + ACC_W'(1)) : {1'b0, quo};
   assign q_lim    = (bneg_ff ^ dneg_ff) ? Q_NEG_LIM : Q_POS_LIM;
   assign t2       = prod_ff >> FRAC_BITS;

   assign add_func   = sat_add(sum_func_ff, t1_ff);
   assign add_first  = sat_add(sum_first_ff, t2);
   assign add_second = sat_add(sum_second_ff, t3_ff);

   assign lam_c      = {shift_ff[DATA_W-1], shift_ff} - {corner_ff[DATA_W-1], corner_ff};
   assign res_func   = sat32({{(ACC_W-DATA_W+1){lam_c[DATA_W]}}, lam_c}
                           + {{2{sum_func_ff[ACC_W-1]}}, sum_func_ff});
   assign res_first  = sat32(ONE_EXT + {{2{sum_first_ff[ACC_W-1]}}, sum_first_ff});
   assign res_second = sat32({sum_second_ff[ACC_W-1], sum_second_ff, 1'b0});

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      shift_in  = shift_ff;
      corner_in = corner_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SHIFT:  shift_in  = csr_wdata;
            CSR_CORNER: corner_in = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      dzero_in = dzero_ff;
      bmag_in  = bmag_ff;
      bneg_in  = bneg_ff;
      last_in  = last_ff;
      if (cmd.load_item) begin
         dneg_in  = d_full[DATA_W];
         dzero_in = (d_full == '0);
         dmag_in  = d_full[DATA_W] ? d_neg[DVS_W-1:0] : d_full[DVS_W-1:0];
         bneg_in  = req_data.spike_entry[DATA_W-1];
         bmag_in  = req_data.spike_entry[DATA_W-1] ? (~req_data.spike_entry + DATA_W'(1))
                                                   : req_data.spike_entry;
         last_in  = req_data.is_last;
      end
   end

   always_comb begin
      t1_in         = t1_ff;
      t3_in         = t3_ff;
      qmag_in       = qmag_ff;
      div_op_in     = div_op_ff;
      sum_func_in   = sum_func_ff;
      sum_first_in  = sum_first_ff;
      sum_second_in = sum_second_ff;
      pole_flag_in  = pole_flag_ff;
      clamp_flag_in = clamp_flag_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.div_start) begin
         div_op_in = cmd.div_op;
      end

      if (div_done) begin
         unique case (div_op_ff)
            DIV_T1: t1_in = quo_term;
            DIV_T3: t3_in = quo_term;
            DIV_Q: begin
               if (quo > q_lim) begin
                  qmag_in       = q_lim[DATA_W-1:0];
                  clamp_flag_in = 1'b1;
               end else begin
                  qmag_in = quo[DATA_W-1:0];
               end
            end
            default: ;
         endcase
      end

      if (cmd.accum) begin
         if (dzero_ff) begin
            pole_flag_in = 1'b1;
         end else begin
            sum_func_in   = add_func[ACC_W-1:0];
            sum_first_in  = add_first[ACC_W-1:0];
            sum_second_in = add_second[ACC_W-1:0];
            clamp_flag_in = clamp_flag_ff || add_func[ACC_W] || add_first[ACC_W]
                          || add_second[ACC_W];
         end
      end

      if (cmd.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.func_value   = res_func[DATA_W-1:0];
         rsp_data_in.first_deriv  = res_first[DATA_W-1:0];
         rsp_data_in.second_deriv = res_second[DATA_W-1:0];
         rsp_data_in.pole_hit     = pole_flag_ff;
         rsp_data_in.saturated    = clamp_flag_ff || res_func[DATA_W] || res_first[DATA_W]
                                  || res_second[DATA_W];
         sum_func_in   = '0;
         sum_first_in  = '0;
         sum_second_in = '0;
         pole_flag_in  = 1'b0;
         clamp_flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff     <= dmag_in;
      dneg_ff     <= dneg_in;
      dzero_ff    <= dzero_in;
      bmag_ff     <= bmag_in;
      bneg_ff     <= bneg_in;
      last_ff     <= last_in;
      t1_ff       <= t1_in;
      t3_ff       <= t3_in;
      qmag_ff     <= qmag_in;
      div_op_ff   <= div_op_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.mul_bb || cmd.mul_qq) begin
         prod_ff <= prod_in;
      end
      if (reset) begin
         shift_ff      <= '0;
         corner_ff     <= '0;
         sum_func_ff   <= '0;
         sum_first_ff  <= '0;
         sum_second_ff <= '0;
         pole_flag_ff  <= 1'b0;
         clamp_flag_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         shift_ff      <= shift_in;
         corner_ff     <= corner_in;
         sum_func_ff   <= sum_func_in;
         sum_first_ff  <= sum_first_in;
         sum_second_ff <= sum_second_in;
         pole_flag_ff  <= pole_flag_in;
         clamp_flag_ff <= clamp_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign sts.pole     = dzero_ff;
   assign sts.is_last  = last_ff;
   assign sts.div_done = div_done;
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/sfe_ctrl.sv =====
// sfe_ctrl: steps one item through two multiplies, three divides and accumulate
// a pole item skips to accumulate, a last item ends in emit; depends on sfe_pkg

module sfe_ctrl import sfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_BB;
         ST_MUL_BB:  state_in = sts.pole ? ST_ACCUM : ST_DIV_T1;
         ST_DIV_T1:  state_in = ST_WAIT_T1;
         ST_WAIT_T1: if (sts.div_done) state_in = ST_DIV_Q;
         ST_DIV_Q:   state_in = ST_WAIT_Q;
         ST_WAIT_Q:  if (sts.div_done) state_in = ST_MUL_QQ;
         ST_MUL_QQ:  state_in = ST_DIV_T3;
         ST_DIV_T3:  state_in = ST_WAIT_T3;
         ST_WAIT_T3: if (sts.div_done) state_in = ST_ACCUM;
         ST_ACCUM:   state_in = sts.is_last ? ST_EMIT : ST_IDLE;
         ST_EMIT:    if (sts.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.div_op = DIV_T1;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         ST_MUL_BB: cmd.mul_bb = 1'b1;
         ST_DIV_T1: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_T1;
         end
         ST_DIV_Q: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_Q;
         end
         ST_MUL_QQ: cmd.mul_qq = 1'b1;
         ST_DIV_T3: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_T3;
         end
         ST_ACCUM: cmd.accum = 1'b1;
         ST_EMIT:  cmd.emit  = sts.out_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/secular_function_evaluator_core.sv =====
// An item runs from accept to the next accept through two multiplies, three passes of
// the shared restoring divider (63-bit quotient each) and accumulate. An item whose
// diagonal entry equals the shift skips the divides and the q*q multiply. A last item
// ends in emit, which loads the result; one result beat may wait while the next item runs.
// Reset is synchronous: state, shift and corner registers, sums and flags clear, block is ready in the next cycle.
// Depends on sfe_pkg, sfe_ctrl, sfe_datapath, sfe_div.

module secular_function_evaluator_core import sfe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   sfe_ctrl u_sfe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sfe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sfe_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ===== hw/rtl/sfe_checker.sv =====
// sfe_checker: port-level checks on the evaluator core, bound to the top level
// depends on sfe_pkg and secular_function_evaluator_core

module sfe_checker import sfe_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while previous item still in work");

   // out of reset: ready for input, no result pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("bad state after reset");

   // a new result is only produced while an item is in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in work");

endmodule

bind secular_function_evaluator_core sfe_checker u_sfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
